// ===== design/bsfd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsfd_pkg
// Shared types, constants and the CRC byte step for the byte-stuffed frame
// deframer.
// ----------------------------------------------------------------------------
package bsfd_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned COUNT_W         = 11;
  localparam int unsigned CRC_W           = 16;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 16;
  localparam int unsigned EV_W            = 3;
  localparam int unsigned MAX_FRAME_BYTES = 1024;

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [CRC_W-1:0]   crc_t;

  localparam crc_t   CRC_SEED  = 16'hFFFF;
  localparam crc_t   CRC_POLY  = 16'h8408;
  localparam count_t COUNT_MAX = COUNT_W'(MAX_FRAME_BYTES);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_BYTE     = 3'd0,
    REG_END_BYTE       = 3'd1,
    REG_ESCAPE_BYTE    = 3'd2,
    REG_ESC_START_CODE = 3'd3,
    REG_ESC_END_CODE   = 3'd4,
    REG_MIN_FRAME      = 3'd5,
    REG_CRC_RESIDUE    = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_ERROR   = 2'd1,
    MODE_FILLING = 2'd2
  } mode_t;

  typedef enum logic [EV_W-1:0] {
    EV_PAYLOAD     = 3'd0,
    EV_FRAME_GOOD  = 3'd1,
    EV_CRC_ERROR   = 3'd2,
    EV_TOO_SHORT   = 3'd3,
    EV_STRAY_DATA  = 3'd4,
    EV_START_IN_FR = 3'd5,
    EV_END_AFT_ESC = 3'd6,
    EV_BAD_ESCAPE  = 3'd7
  } ev_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_OPEN,
    ACT_STRAY,
    ACT_RESTART,
    ACT_END_ESC,
    ACT_CLOSE,
    ACT_PUSH,
    ACT_BAD_ESC,
    ACT_ESC_SET
  } act_t;

  typedef struct packed {
    byte_t  start_byte;
    byte_t  end_byte;
    byte_t  escape_byte;
    byte_t  esc_start_code;
    byte_t  esc_end_code;
    count_t min_frame_bytes;
    crc_t   crc_good_residue;
  } cfg_t;

  typedef struct packed {
    mode_t  mode;
    logic   escape_pending;
    crc_t   crc;
    count_t count;
  } state_t;

  typedef struct packed {
    ev_t    ev;
    byte_t  payload;
    count_t frame_bytes;
    crc_t   crc;
  } result_t;

  // Reflected CRC-16 (X.25) over one byte, least significant bit first.
  function automatic crc_t crc_step(crc_t crc, byte_t b);
    crc_t c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int i = 0; i < BYTE_W; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/bsfd_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsfd_cfg_regs
// Configuration register file: framing bytes, escape codes, minimum frame
// length and the expected CRC residue.
// ----------------------------------------------------------------------------
module bsfd_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bsfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsfd_pkg::CFG_DATA_W-1:0] cfg_data,
  output bsfd_pkg::cfg_t                 cfg
);
  import bsfd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte       <= 8'd126;
      cfg.end_byte         <= 8'd127;
      cfg.escape_byte      <= 8'd125;
      cfg.esc_start_code   <= 8'd94;
      cfg.esc_end_code     <= 8'd95;
      cfg.min_frame_bytes  <= 11'd8;
      cfg.crc_good_residue <= 16'd61624;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_START_BYTE:     cfg.start_byte       <= cfg_data[BYTE_W-1:0];
        REG_END_BYTE:       cfg.end_byte         <= cfg_data[BYTE_W-1:0];
        REG_ESCAPE_BYTE:    cfg.escape_byte      <= cfg_data[BYTE_W-1:0];
        REG_ESC_START_CODE: cfg.esc_start_code   <= cfg_data[BYTE_W-1:0];
        REG_ESC_END_CODE:   cfg.esc_end_code     <= cfg_data[BYTE_W-1:0];
        REG_MIN_FRAME:      cfg.min_frame_bytes  <= cfg_data[COUNT_W-1:0];
        REG_CRC_RESIDUE:    cfg.crc_good_residue <= cfg_data[CRC_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/bsfd_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsfd_step
// Deframing step for one received byte: classifies the byte against the
// framing state, computes the next state and the result item, if any.
// ----------------------------------------------------------------------------
module bsfd_step (
  input  bsfd_pkg::cfg_t    cfg,
  input  bsfd_pkg::state_t  st,
  input  bsfd_pkg::byte_t   rx,
  output bsfd_pkg::state_t  st_next,
  output bsfd_pkg::result_t res,
  output logic              res_valid
);
  import bsfd_pkg::*;

  act_t  act;
  byte_t lit;

  always_comb begin
    act = ACT_NONE;
    lit = rx;
    if (st.mode != MODE_FILLING) begin
      if (rx == cfg.start_byte) begin
        act = ACT_OPEN;
      end else if (st.mode == MODE_IDLE) begin
        act = ACT_STRAY;
      end
    end else if (rx == cfg.start_byte) begin
      act = ACT_RESTART;
    end else if (rx == cfg.end_byte) begin
      act = st.escape_pending ? ACT_END_ESC : ACT_CLOSE;
    end else if (st.escape_pending) begin
      priority if (rx == cfg.escape_byte) begin
        act = ACT_PUSH;
        lit = cfg.escape_byte;
      end else if (rx == cfg.esc_start_code) begin
        act = ACT_PUSH;
        lit = cfg.start_byte;
      end else if (rx == cfg.esc_end_code) begin
        act = ACT_PUSH;
        lit = cfg.end_byte;
      end else begin
        act = ACT_BAD_ESC;
      end
    end else if (rx == cfg.escape_byte) begin
      act = ACT_ESC_SET;
    end else begin
      act = ACT_PUSH;
    end
  end

  always_comb begin
    st_next = st;
    unique case (act)
      ACT_OPEN, ACT_RESTART: begin
        st_next.mode           = MODE_FILLING;
        st_next.escape_pending = 1'b0;
        st_next.crc            = CRC_SEED;
        st_next.count          = '0;
      end
      ACT_STRAY:   st_next.mode = MODE_ERROR;
      ACT_END_ESC, ACT_BAD_ESC: begin
        st_next.escape_pending = 1'b0;
        st_next.mode           = MODE_ERROR;
      end
      ACT_CLOSE:   st_next.mode = MODE_IDLE;
      ACT_PUSH: begin
        st_next.escape_pending = 1'b0;
        st_next.crc            = crc_step(st.crc, lit);
        st_next.count          = (st.count < COUNT_MAX) ? st.count + 1'b1 : st.count;
      end
      ACT_ESC_SET: st_next.escape_pending = 1'b1;
      ACT_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_valid       = 1'b1;
    res.ev          = EV_PAYLOAD;
    res.payload     = '0;
    res.frame_bytes = st_next.count;
    res.crc         = st_next.crc;
    unique case (act)
      ACT_PUSH: res.payload = lit;
      ACT_STRAY:   res.ev = EV_STRAY_DATA;
      ACT_RESTART: res.ev = EV_START_IN_FR;
      ACT_END_ESC: res.ev = EV_END_AFT_ESC;
      ACT_BAD_ESC: res.ev = EV_BAD_ESCAPE;
      ACT_CLOSE: begin
        if (st.count < cfg.min_frame_bytes) begin
          res.ev = EV_TOO_SHORT;
        end else if (st.crc != cfg.crc_good_residue) begin
          res.ev = EV_CRC_ERROR;
        end else begin
          res.ev = EV_FRAME_GOOD;
        end
      end
      ACT_NONE, ACT_OPEN, ACT_ESC_SET: res_valid = 1'b0;
      default: res_valid = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/byte_stuffed_frame_deframer_crc16_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stuffed_frame_deframer_crc16_core
// Removes start, end and escape framing from a received byte stream, checks
// each frame with CRC-16/X.25 and reports payload bytes and frame events.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle and can sustain that rate without
// gaps while the output is ready. A byte is held in an input register, goes
// through the combinational deframing logic and CRC byte step, and its result
// item, if it causes one, is loaded into the output register as the byte
// leaves the input register. A stalled output holds back the input only once
// both registers are full. Configuration takes effect on the next byte.
module byte_stuffed_frame_deframer_crc16_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bsfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsfd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      event_res,
  output logic [7:0]                      payload_byte,
  output logic [10:0]                     frame_bytes,
  output logic [15:0]                     crc_value
);
  import bsfd_pkg::*;

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  result_t res;
  result_t out_res;
  logic    res_valid;
  logic    in_full;
  byte_t   in_byte;
  logic    fire;

  bsfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bsfd_step u_step (
    .cfg       (cfg),
    .st        (st),
    .rx        (in_byte),
    .st_next   (st_next),
    .res       (res),
    .res_valid (res_valid)
  );

  assign fire     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode           <= MODE_IDLE;
      st.escape_pending <= 1'b0;
      st.crc            <= CRC_SEED;
      st.count          <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_res <= res;
    end
  end

  assign event_res    = out_res.ev;
  assign payload_byte = out_res.payload;
  assign frame_bytes  = out_res.frame_bytes;
  assign crc_value    = out_res.crc;

`ifndef ASSERT_OFF
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    fire && res_valid |=> out_valid)
    else $error("Result item was not loaded into the output register.");

  a_escape_only_in_frame: assert property (@(posedge clk) disable iff (rst)
    st.mode != MODE_FILLING |-> !st.escape_pending)
    else $error("Escape pending outside a frame.");

  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    st.count <= COUNT_MAX)
    else $error("Frame byte count exceeds its maximum.");

  a_held_item_stays: assert property (@(posedge clk) disable iff (rst)
    in_full && !fire |=> in_full && $stable(in_byte))
    else $error("Held input item was lost or changed.");

  a_restart_reseeds: assert property (@(posedge clk) disable iff (rst)
    fire && res_valid && res.ev == EV_START_IN_FR |=> st.crc == CRC_SEED && st.count == '0)
    else $error("Frame restart did not reseed the CRC and count.");
`endif

endmodule
`default_nettype wire
